// ----- hw/rtl/tlts_pkg.sv -----
// ----------------------------------------------------------------------------
// tlts_pkg
// Shared types and constants for the timed line table search core.
// ----------------------------------------------------------------------------
package tlts_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;

  localparam int KIND_W   = 2;
  localparam int TS_W     = 32;
  localparam int STATUS_W = 2;
  localparam int ROW_W    = 10;
  localparam int COUNT_W  = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_POLL   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // latch the incoming item
    logic append;    // append attempt
    logic clear;     // empty the table
    logic s1_init;   // upper bound search over [0, count)
    logic s1_step;
    logic ub_cap;    // upper bound found
    logic key_rd;    // read row ub-1
    logic key_cap;   // capture key, set up earliest-row search
    logic s2_step;
    logic arow_cap;  // active row found
    logic nxt_rd;    // read row ub
    logic nxt_cap;
    logic post;      // highlight bookkeeping
    logic load_out;  // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  srch_done;
    logic  ub_zero;
    logic  ub_lt_count;
    logic  out_free;
  } sts_t;

endpackage

// ----- hw/rtl/timed_line_table_search_core.sv -----
// ----------------------------------------------------------------------------
// timed_line_table_search_core
// Sorted start time table with append, clear, lookup and highlight poll.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | kind, time_ms
//   out     | out_valid / out_stall| status, active_*, next_*,
//           |                      | highlight_changed, line_count
//
// append and clear pass from accept through decode to the result; lookup and
// poll run two binary searches whose steps each read a row, then compare it,
// on the table's single read port. one item is in work at a time.
// reset empties the table at once; the table contents need no clearing pass.
// a stalled result sits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module timed_line_table_search_core #(
  parameter int TABLE_DEPTH = tlts_pkg::DEF_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tlts_pkg::KIND_W-1:0]    kind,
  input  logic [tlts_pkg::TS_W-1:0]      time_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tlts_pkg::STATUS_W-1:0]  status,
  output logic                           active_found,
  output logic [tlts_pkg::ROW_W-1:0]     active_line,
  output logic [tlts_pkg::TS_W-1:0]      active_ts,
  output logic                           next_found,
  output logic [tlts_pkg::ROW_W-1:0]     next_line,
  output logic [tlts_pkg::TS_W-1:0]      next_ts,
  output logic                           highlight_changed,
  output logic [tlts_pkg::COUNT_W-1:0]   line_count
);
  import tlts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlts_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .kind              (kind),
    .time_ms           (time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .active_found      (active_found),
    .active_line       (active_line),
    .active_ts         (active_ts),
    .next_found        (next_found),
    .next_line         (next_line),
    .next_ts           (next_ts),
    .highlight_changed (highlight_changed),
    .line_count        (line_count)
  );

endmodule

// ----- hw/rtl/tlts_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlts_ctrl
// Sequencer for appends, clears and the two binary searches of a lookup or poll.
// ----------------------------------------------------------------------------
module tlts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tlts_pkg::sts_t sts,
  output tlts_pkg::cmd_t cmd
);
  import tlts_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_DECODE   = 12'b000000000010,
    S_S1_RD    = 12'b000000000100,
    S_S1_CMP   = 12'b000000001000,
    S_KEY_RD   = 12'b000000010000,
    S_KEY_CAP  = 12'b000000100000,
    S_S2_RD    = 12'b000001000000,
    S_S2_CMP   = 12'b000010000000,
    S_NXT_RD   = 12'b000100000000,
    S_NXT_CAP  = 12'b001000000000,
    S_POST     = 12'b010000000000,
    S_FIN      = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.kind inside {KIND_LOOKUP, KIND_POLL}) begin
          cmd.s1_init = 1'b1;
          state_next  = S_S1_RD;
        end else begin
          cmd.append = (sts.kind == KIND_APPEND);
          cmd.clear  = (sts.kind == KIND_CLEAR);
          state_next = S_FIN;
        end
      end
      S_S1_RD: begin
        // read of the middle row is issued here, compared next cycle
        if (sts.srch_done) begin
          cmd.ub_cap = 1'b1;
          state_next = S_KEY_RD;
        end else begin
          state_next = S_S1_CMP;
        end
      end
      S_S1_CMP: begin
        cmd.s1_step = 1'b1;
        state_next  = S_S1_RD;
      end
      S_KEY_RD: begin
        if (sts.ub_zero) begin
          state_next = S_NXT_RD;
        end else begin
          cmd.key_rd = 1'b1;
          state_next = S_KEY_CAP;
        end
      end
      S_KEY_CAP: begin
        cmd.key_cap = 1'b1;
        state_next  = S_S2_RD;
      end
      S_S2_RD: begin
        if (sts.srch_done) begin
          cmd.arow_cap = 1'b1;
          state_next   = S_NXT_RD;
        end else begin
          state_next = S_S2_CMP;
        end
      end
      S_S2_CMP: begin
        cmd.s2_step = 1'b1;
        state_next  = S_S2_RD;
      end
      S_NXT_RD: begin
        if (sts.ub_lt_count) begin
          cmd.nxt_rd = 1'b1;
          state_next = S_NXT_CAP;
        end else begin
          state_next = S_POST;
        end
      end
      S_NXT_CAP: begin
        cmd.nxt_cap = 1'b1;
        state_next  = S_POST;
      end
      S_POST: begin
        cmd.post   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tlts_dp.sv -----
// ----------------------------------------------------------------------------
// tlts_dp
// Start time table, search bounds, highlight state and output register.
// ----------------------------------------------------------------------------
module tlts_dp #(
  parameter int TABLE_DEPTH = tlts_pkg::DEF_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tlts_pkg::cmd_t                 cmd,
  output tlts_pkg::sts_t                 sts,
  input  logic [tlts_pkg::KIND_W-1:0]    kind,
  input  logic [tlts_pkg::TS_W-1:0]      time_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tlts_pkg::STATUS_W-1:0]  status,
  output logic                           active_found,
  output logic [tlts_pkg::ROW_W-1:0]     active_line,
  output logic [tlts_pkg::TS_W-1:0]      active_ts,
  output logic                           next_found,
  output logic [tlts_pkg::ROW_W-1:0]     next_line,
  output logic [tlts_pkg::TS_W-1:0]      next_ts,
  output logic                           highlight_changed,
  output logic [tlts_pkg::COUNT_W-1:0]   line_count
);
  import tlts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [TS_W-1:0] mem [TABLE_DEPTH];
  logic [TS_W-1:0] mem_q;
  logic [AW-1:0]   raddr;
  logic            we;

  kind_t           kind_q;
  logic [TS_W-1:0] t_q;
  logic [TS_W-1:0] last_ts;
  logic [CW-1:0]   count;
  logic [CW-1:0]   lo, hi, mid, ub, ub_m1;
  logic            hl_valid;
  logic [AW-1:0]   hl_row;

  status_t         st_q, app_status;
  logic            a_found, n_found, hl_chg;
  logic [AW-1:0]   a_row, n_row;
  logic [TS_W-1:0] a_ts, n_ts;
  logic            same;
  logic            poll_upd;

  assign mid   = lo + ((hi - lo) >> 1);
  assign ub_m1 = ub - 1'b1;

  always_comb begin
    if (count >= CW'(TABLE_DEPTH)) begin
      app_status = ST_FULL;
    end else if ((count != '0) && (t_q < last_ts)) begin
      app_status = ST_ORDER;
    end else begin
      app_status = ST_OK;
    end
  end

  assign we = cmd.append && (app_status == ST_OK);

  always_comb begin
    raddr = mid[AW-1:0];
    if (cmd.key_rd) begin
      raddr = ub_m1[AW-1:0];
    end else if (cmd.nxt_rd) begin
      raddr = ub[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[count[AW-1:0]] <= t_q;
    end
    mem_q <= mem[raddr];
  end

  assign same = (a_found == hl_valid) && (!a_found || (a_row == hl_row));
  assign poll_upd = cmd.post && (kind_q == KIND_POLL) && !same;

  assign sts.kind        = kind_q;
  assign sts.srch_done   = (lo >= hi);
  assign sts.ub_zero     = (ub == '0);
  assign sts.ub_lt_count = (ub < count);
  assign sts.out_free    = !out_valid || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      hl_valid  <= 1'b0;
      hl_row    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (we) begin
        count <= count + 1'b1;
      end
      if (cmd.clear) begin
        count    <= '0;
        hl_valid <= 1'b0;
        hl_row   <= '0;
      end
      if (poll_upd) begin
        hl_valid <= a_found;
        hl_row   <= a_found ? a_row : '0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_q  <= kind_t'(kind);
      t_q     <= time_ms;
      st_q    <= ST_OK;
      a_found <= 1'b0;
      a_row   <= '0;
      a_ts    <= '0;
      n_found <= 1'b0;
      n_row   <= '0;
      n_ts    <= '0;
      hl_chg  <= 1'b0;
    end
    if (cmd.append) begin
      st_q <= app_status;
    end
    if (we) begin
      last_ts <= t_q;
    end
    if (cmd.clear) begin
      hl_chg <= hl_valid;
    end
    if (cmd.s1_init) begin
      lo <= '0;
      hi <= count;
    end
    if (cmd.s1_step) begin
      if (mem_q > t_q) begin
        hi <= mid;
      end else begin
        lo <= mid + 1'b1;
      end
    end
    if (cmd.ub_cap) begin
      ub <= lo;
    end
    // earliest row holding the key lies in [0, ub-1]
    if (cmd.key_cap) begin
      a_ts <= mem_q;
      lo   <= '0;
      hi   <= ub_m1;
    end
    if (cmd.s2_step) begin
      if (mem_q >= a_ts) begin
        hi <= mid;
      end else begin
        lo <= mid + 1'b1;
      end
    end
    if (cmd.arow_cap) begin
      a_found <= 1'b1;
      a_row   <= lo[AW-1:0];
    end
    if (cmd.nxt_cap) begin
      n_found <= 1'b1;
      n_row   <= ub[AW-1:0];
      n_ts    <= mem_q;
    end
    if (poll_upd) begin
      hl_chg <= 1'b1;
    end
    if (cmd.load_out) begin
      status            <= st_q;
      active_found      <= a_found;
      active_line       <= ROW_W'(a_row);
      active_ts         <= a_ts;
      next_found        <= n_found;
      next_line         <= ROW_W'(n_row);
      next_ts           <= n_ts;
      highlight_changed <= hl_chg;
      line_count        <= COUNT_W'(count);
    end
  end

endmodule
